### design/fskd_pkg.sv
// ----------------------------------------------------------------------------
// FSK interval bit decoder package
// Shared widths, register codes, state and configuration types, and the
// small helper functions used by the decoding step.
// ----------------------------------------------------------------------------
`default_nettype none

package fskd_pkg;

   localparam int WORD_BITS    = 16;
   localparam int BIT_LIMIT    = ((2 * WORD_BITS) > 63) ? 63 : (2 * WORD_BITS);
   localparam int CNT_W        = $clog2(BIT_LIMIT + 1);
   localparam int IVL_W        = 16;
   localparam int TOL_W        = 8;
   localparam int CYC_W        = 8;
   localparam int RSP_FIELDS_W = 2 * WORD_BITS + CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic TONE_LOW  = 1'b0;
   localparam logic TONE_HIGH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_TONE    = 3'd0,
      CSR_HIGH_TONE   = 3'd1,
      CSR_SWITCH      = 3'd2,
      CSR_TOLERANCE   = 3'd3,
      CSR_LOW_CYCLES  = 3'd4,
      CSR_HIGH_CYCLES = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [IVL_W-1:0] low_tone;
      logic [IVL_W-1:0] high_tone;
      logic [IVL_W-1:0] switch_ivl;
      logic [TOL_W-1:0] tolerance;
      logic [CYC_W-1:0] low_cycles;
      logic [CYC_W-1:0] high_cycles;
   } cfg_type;

   typedef struct packed {
      logic                 tone_mode;
      logic [CYC_W-1:0]     low_count;
      logic [CYC_W-1:0]     high_count;
      logic [CNT_W-1:0]     bits_done;
      logic [WORD_BITS-1:0] low_shift;
      logic [WORD_BITS-1:0] high_shift;
   } st_type;

   localparam cfg_type CFG_RESET = '{
      low_tone:    16'h007C,
      high_tone:   16'h003E,
      switch_ivl:  16'h005C,
      tolerance:   8'd3,
      low_cycles:  8'd10,
      high_cycles: 8'd20
   };

   function automatic logic near_value(input logic [IVL_W-1:0] v,
                                       input logic [IVL_W-1:0] nominal,
                                       input logic [TOL_W-1:0] tol);
      logic [IVL_W:0] v_up;
      logic [IVL_W:0] n_up;
      v_up = {1'b0, v} + {{(IVL_W - TOL_W + 1){1'b0}}, tol};
      n_up = {1'b0, nominal} + {{(IVL_W - TOL_W + 1){1'b0}}, tol};
      return (v_up > {1'b0, nominal}) && ({1'b0, v} < n_up);
   endfunction

   function automatic logic in_window(input logic [CYC_W-1:0] count,
                                      input logic [CYC_W-1:0] target);
      logic [CYC_W:0] c_up;
      logic [CYC_W:0] t_up;
      c_up = {1'b0, count} + {{CYC_W{1'b0}}, 1'b1};
      t_up = {1'b0, target} + {{CYC_W{1'b0}}, 1'b1};
      return (c_up >= {1'b0, target}) && ({1'b0, count} <= t_up);
   endfunction

   function automatic logic [CYC_W-1:0] inc_sat(input logic [CYC_W-1:0] count);
      return (count == {CYC_W{1'b1}}) ? count : count + {{(CYC_W-1){1'b0}}, 1'b1};
   endfunction

   function automatic st_type push_bit(input st_type st, input logic value);
      st_type res;
      res = st;
      if (st.bits_done < CNT_W'(WORD_BITS)) begin
         res.low_shift = {value, st.low_shift[WORD_BITS-1:1]};
      end else begin
         res.high_shift = {value, st.high_shift[WORD_BITS-1:1]};
      end
      if (st.bits_done < CNT_W'(BIT_LIMIT)) begin
         res.bits_done = st.bits_done + CNT_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### design/fsk_interval_bit_decoder.sv
// ----------------------------------------------------------------------------
// FSK interval bit decoder
// Decodes rising-edge intervals of a two-tone FSK signal into bits by
// counting tone cycles, and reports the decoded words after every interval.
// An accepted interval waits in the input register; its result moves to the
// result register when the output is free. Throughput: one interval per cycle
// unless rsp_tready stalls; decoding is one pass of compare and count logic.
// Reset: synchronous; clears the pipeline, the tone state and the decoded
// words, and loads the registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_interval_bit_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // interval [15:0]
   input  logic [fskd_pkg::IVL_W-1:0]          req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // low_word [15:0], high_word [31:16], bits_received [37:32], zero fill
   output logic [fskd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // bit_emitted [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fskd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fskd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fskd_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   st_type                 st_ff;
   st_type                 st_in;
   logic                   emit;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [IVL_W-1:0]       in_ivl_ff;
   logic                   in_last_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic                   rsp_emit_ff;
   logic                   rsp_last_ff;
   logic                   out_free;
   logic                   advance;
   logic                   req_fire;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_TONE:    cfg_in.low_tone    = csr_data;
            CSR_HIGH_TONE:   cfg_in.high_tone   = csr_data;
            CSR_SWITCH:      cfg_in.switch_ivl  = csr_data;
            CSR_TOLERANCE:   cfg_in.tolerance   = csr_data[TOL_W-1:0];
            CSR_LOW_CYCLES:  cfg_in.low_cycles  = csr_data[CYC_W-1:0];
            CSR_HIGH_CYCLES: cfg_in.high_cycles = csr_data[CYC_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   fskd_step u_step (
      .cfg_i      (cfg_ff),
      .st_i       (st_ff),
      .interval_i (in_ivl_ff),
      .st_o       (st_in),
      .emit_o     (emit)
   );

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         st_ff        <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ivl_ff  <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_data_ff <= RSP_DATA_W'({st_in.bits_done, st_in.high_shift, st_in.low_shift});
         rsp_emit_ff <= emit;
         rsp_last_ff <= in_last_ff;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_emit_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      st_ff.bits_done <= CNT_W'(BIT_LIMIT))
      else $error("bit count above its limit");

   a_count_needs_emit: assert property (@(posedge clock) disable iff (reset)
      (advance && (st_in.bits_done != st_ff.bits_done)) |-> emit)
      else $error("bit count changed without a decoded bit");

   a_emit_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && (st_ff.bits_done < CNT_W'(BIT_LIMIT)))
         |-> (st_in.bits_done > st_ff.bits_done))
      else $error("decoded bit not counted");

   a_zero_tol_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && (cfg_ff.tolerance == '0)) |-> (st_in == st_ff) && !emit)
      else $error("state changed with zero tolerance");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled while the pipeline can move");

endmodule

`default_nettype wire

### design/fskd_step.sv
// ----------------------------------------------------------------------------
// FSK interval decoding step
// Classifies one interval against the three nominal values and works out
// the next tone mode, cycle counts, bit count and shift words.
// ----------------------------------------------------------------------------
`default_nettype none

module fskd_step (
   input  fskd_pkg::cfg_type          cfg_i,
   input  fskd_pkg::st_type           st_i,
   input  logic [fskd_pkg::IVL_W-1:0] interval_i,
   output fskd_pkg::st_type           st_o,
   output logic                       emit_o
);
   import fskd_pkg::*;

   logic   hit_low;
   logic   hit_high;
   logic   hit_switch;
   st_type st;
   logic   emit;

   assign hit_low    = near_value(interval_i, cfg_i.low_tone, cfg_i.tolerance);
   assign hit_high   = near_value(interval_i, cfg_i.high_tone, cfg_i.tolerance);
   assign hit_switch = near_value(interval_i, cfg_i.switch_ivl, cfg_i.tolerance);

   always_comb begin
      st   = st_i;
      emit = 1'b0;
      if (st_i.tone_mode == TONE_LOW) begin
         if (hit_low) begin
            if (st.low_count == cfg_i.low_cycles) begin
               st           = push_bit(st, 1'b0);
               emit         = 1'b1;
               st.low_count = '0;
            end
            st.low_count = inc_sat(st.low_count);
         end
         if (hit_high) begin
            st.tone_mode = TONE_HIGH;
            if (in_window(st.low_count, cfg_i.low_cycles)) begin
               st   = push_bit(st, 1'b0);
               emit = 1'b1;
            end
            st.low_count  = '0;
            st.high_count = inc_sat(st.high_count);
         end
         if (hit_switch) begin
            st.tone_mode = TONE_HIGH;
            st.low_count = inc_sat(st.low_count);
            if (in_window(st.low_count, cfg_i.low_cycles)) begin
               st   = push_bit(st, 1'b0);
               emit = 1'b1;
            end
            st.low_count = '0;
         end
      end else begin
         if (hit_high) begin
            if (st.high_count == cfg_i.high_cycles) begin
               st            = push_bit(st, 1'b1);
               emit          = 1'b1;
               st.high_count = '0;
            end
            st.high_count = inc_sat(st.high_count);
         end
         if (hit_low) begin
            st.tone_mode = TONE_LOW;
            if (in_window(st.high_count, cfg_i.high_cycles)) begin
               st   = push_bit(st, 1'b1);
               emit = 1'b1;
            end
            st.high_count = '0;
            st.low_count  = inc_sat(st.low_count);
         end
         if (hit_switch) begin
            st.tone_mode  = TONE_LOW;
            st.high_count = inc_sat(st.high_count);
            if (in_window(st.high_count, cfg_i.high_cycles)) begin
               st   = push_bit(st, 1'b1);
               emit = 1'b1;
            end
            st.high_count = '0;
         end
      end
   end

   assign st_o   = st;
   assign emit_o = emit;

endmodule

`default_nettype wire
